### hdl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared widths, constants and types for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int CTR_W       = 12;   // center and step coordinate width
  localparam int RAD_W       = 11;
  localparam int OUT_W       = 14;
  localparam int DEC_W       = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DEC_W-1:0] DEC_SEED = DEC_W'(3);
  localparam logic [DEC_W-1:0] STEP_NEG = DEC_W'(6);
  localparam logic [DEC_W-1:0] STEP_POS = DEC_W'(10);

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef struct packed {
    logic             fin;
    logic [CTR_W-1:0] cx;
    logic [CTR_W-1:0] cy;
    logic [CTR_W-1:0] x;
    logic [CTR_W-1:0] y;   // two's complement
  } mcr_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } mcr_qstat_t;

endpackage

### hdl/mcr_in_if.sv
// ----------------------------------------------------------------------------
// mcr_in_if
// Input item channel: start or advance command with center and radius.
// ----------------------------------------------------------------------------
interface mcr_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [11:0] center_x;
  logic [11:0] center_y;
  logic [10:0] radius;

  modport source (output valid, output func, output center_x, output center_y,
                  output radius, input ready);
  modport sink   (input valid, input func, input center_x, input center_y,
                  input radius, output ready);
endinterface

### hdl/mcr_out_if.sv
// ----------------------------------------------------------------------------
// mcr_out_if
// Result channel: one pixel or one finished marker per transfer.
// ----------------------------------------------------------------------------
interface mcr_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] point_x;
  logic signed [13:0] point_y;
  logic               point_valid;
  logic               last;
  logic               finished;

  modport source (output valid, output point_x, output point_y,
                  output point_valid, output last, output finished, input ready);
  modport sink   (input valid, input point_x, input point_y,
                  input point_valid, input last, input finished, output ready);
endinterface

### hdl/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// Accepts items, keeps the circle state and issues one step command per item.
// ----------------------------------------------------------------------------
module mcr_front #(
  parameter int COORD_WIDTH = 12
) (
  input  logic              clk,
  input  logic              rst,
  mcr_in_if.sink            items,
  output mcr_pkg::mcr_cmd_t cmd,
  output logic              push,
  input  mcr_pkg::mcr_qstat_t qstat
);
  import mcr_pkg::*;

  localparam int HeldW = (COORD_WIDTH < CTR_W) ? COORD_WIDTH : CTR_W;
  localparam logic [CTR_W-1:0] CenterMask = CTR_W'((64'd1 << HeldW) - 64'd1);

  logic [CTR_W-1:0] held_cx;
  logic [CTR_W-1:0] held_cy;
  logic [CTR_W-1:0] step_x;
  logic [CTR_W-1:0] step_y;
  logic [DEC_W-1:0] decision;
  logic             active;

  logic             start;
  logic [CTR_W-1:0] new_cx;
  logic [CTR_W-1:0] new_cy;
  logic [CTR_W-1:0] eff_x;
  logic [CTR_W-1:0] eff_y;
  logic [DEC_W-1:0] eff_d;
  logic             eff_active;
  logic             fin;
  logic [DEC_W-1:0] x16;
  logic [DEC_W-1:0] y16;
  logic [DEC_W-1:0] decision_next;

  assign items.ready = !qstat.full;
  assign push        = items.valid && !qstat.full;
  assign start       = (items.func == FUNC_START);

  assign new_cx = items.center_x & CenterMask;
  assign new_cy = items.center_y & CenterMask;

  always_comb begin
    eff_x      = start ? '0 : step_x;
    eff_y      = start ? {1'b0, items.radius} : step_y;
    eff_d      = start ? (DEC_SEED - {{(DEC_W-RAD_W-1){1'b0}}, items.radius, 1'b0})
                       : decision;
    eff_active = start || active;
    fin        = !eff_active ||
                 ($signed({1'b0, eff_x}) > $signed({eff_y[CTR_W-1], eff_y}));
    x16        = {{(DEC_W-CTR_W){1'b0}}, eff_x};
    y16        = {{(DEC_W-CTR_W){eff_y[CTR_W-1]}}, eff_y};
    if (eff_d[DEC_W-1]) begin
      decision_next = eff_d + (x16 << 2) + STEP_NEG;
    end else begin
      decision_next = eff_d + ((x16 - y16) << 2) + STEP_POS;
    end
    cmd.fin = fin;
    cmd.cx  = start ? new_cx : held_cx;
    cmd.cy  = start ? new_cy : held_cy;
    cmd.x   = eff_x;
    cmd.y   = eff_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cx  <= '0;
      held_cy  <= '0;
      step_x   <= '0;
      step_y   <= '0;
      decision <= '0;
      active   <= 1'b0;
    end else if (push) begin
      if (start) begin
        held_cx <= new_cx;
        held_cy <= new_cy;
      end
      if (fin) begin
        active <= 1'b0;
        if (start) begin
          step_x   <= eff_x;
          step_y   <= eff_y;
          decision <= eff_d;
        end
      end else begin
        active   <= 1'b1;
        step_x   <= eff_x + 1'b1;
        step_y   <= eff_d[DEC_W-1] ? eff_y : eff_y - 1'b1;
        decision <= decision_next;
      end
    end
  end

endmodule

### hdl/mcr_queue.sv
// ----------------------------------------------------------------------------
// mcr_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module mcr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mcr_pkg::mcr_cmd_t   wr_cmd,
  input  logic                pop,
  output mcr_pkg::mcr_cmd_t   rd_cmd,
  output mcr_pkg::mcr_qstat_t qstat
);
  import mcr_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  mcr_cmd_t        entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign rd_cmd      = entries[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == Full);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// Expands a step command into eight mirrored points, or one finished marker.
// ----------------------------------------------------------------------------
module mcr_back (
  input  logic                clk,
  input  logic                rst,
  input  mcr_pkg::mcr_cmd_t   cmd,
  input  mcr_pkg::mcr_qstat_t qstat,
  output logic                pop,
  mcr_out_if.source           results
);
  import mcr_pkg::*;

  logic [2:0]       idx;
  logic             advance;
  logic             cmd_done;
  logic [OUT_W-1:0] cx14;
  logic [OUT_W-1:0] cy14;
  logic [OUT_W-1:0] x14;
  logic [OUT_W-1:0] y14;
  logic [OUT_W-1:0] off_a;
  logic [OUT_W-1:0] off_b;
  logic [OUT_W-1:0] dx;
  logic [OUT_W-1:0] dy;

  assign advance  = !qstat.empty && (!results.valid || results.ready);
  assign cmd_done = cmd.fin || (&idx);
  assign pop      = advance && cmd_done;

  // first four points mirror (x,y), last four mirror (y,x)
  always_comb begin
    cx14  = {{(OUT_W-CTR_W){1'b0}}, cmd.cx};
    cy14  = {{(OUT_W-CTR_W){1'b0}}, cmd.cy};
    x14   = {{(OUT_W-CTR_W){1'b0}}, cmd.x};
    y14   = {{(OUT_W-CTR_W){cmd.y[CTR_W-1]}}, cmd.y};
    off_a = idx[2] ? y14 : x14;
    off_b = idx[2] ? x14 : y14;
    dx    = (idx[2] ? idx[1] : idx[0]) ? -off_a : off_a;
    dy    = (idx[2] ? idx[0] : idx[1]) ? -off_b : off_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= '0;
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= 1'b1;
      idx           <= cmd_done ? '0 : idx + 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (cmd.fin) begin
        results.point_x     <= '0;
        results.point_y     <= '0;
        results.point_valid <= 1'b0;
        results.last        <= 1'b1;
        results.finished    <= 1'b1;
      end else begin
        results.point_x     <= cx14 + dx;
        results.point_y     <= cy14 + dy;
        results.point_valid <= 1'b1;
        results.last        <= &idx;
        results.finished    <= 1'b0;
      end
    end
  end

endmodule

### hdl/midpoint_circle_rasterizer_unit.sv
// An item passes the command queue and then the output register before its first result.
// A drawing item yields 8 results, one per cycle while results.ready does not hold
//   back the single result register; a finished item yields one result.
// The front keeps accepting while the 2-entry command queue has room.
// Reset (synchronous, active high) clears circle state, queue and output valid.
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// Midpoint circle generator with eight-way symmetric point output.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit #(
  parameter int COORD_WIDTH = 12
) (
  input  logic      clk,
  input  logic      rst,
  mcr_in_if.sink    items,
  mcr_out_if.source results
);
  import mcr_pkg::*;

  mcr_cmd_t   push_cmd;
  mcr_cmd_t   head_cmd;
  mcr_qstat_t qstat;
  logic       push;
  logic       pop;

  mcr_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .cmd   (push_cmd),
    .push  (push),
    .qstat (qstat)
  );

  mcr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .qstat  (qstat)
  );

  mcr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cmd     (head_cmd),
    .qstat   (qstat),
    .pop     (pop),
    .results (results)
  );

`ifndef SYNTH
  a_fin_marker: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.finished |-> results.last && !results.point_valid)
    else $error("finished result without last or with a pixel");

  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> !results.valid && qstat.empty)
    else $error("state not cleared after reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("command queue popped while empty");
`endif

endmodule
